### hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

### hdl/aes_ssr_pkg.sv
// types and s-box contents for the aes subbytes/shiftrows row block
package aes_ssr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RowW   = 2;
  localparam int unsigned SboxDepth = 256;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [RowW-1:0]  row_idx_t;

  typedef struct packed {
    row_idx_t row_index;
    byte_t    in_byte0;
    byte_t    in_byte1;
    byte_t    in_byte2;
    byte_t    in_byte3;
  } row_in_t;

  typedef struct packed {
    byte_t out_byte0;
    byte_t out_byte1;
    byte_t out_byte2;
    byte_t out_byte3;
  } row_out_t;

  // forward s-box: inverse in gf(2^8) then affine transform, xor 0x63
  localparam byte_t SBOX_TABLE [SboxDepth] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage

### hdl/aes_ssr_sbox_rom.sv
// dual-port s-box rom with registered read data
module aes_ssr_sbox_rom (
  input  logic                clk,
  input  aes_ssr_pkg::byte_t  addr_a,
  input  aes_ssr_pkg::byte_t  addr_b,
  output aes_ssr_pkg::byte_t  data_a,
  output aes_ssr_pkg::byte_t  data_b
);

  always_ff @(posedge clk) begin
    data_a <= aes_ssr_pkg::SBOX_TABLE[addr_a];
    data_b <= aes_ssr_pkg::SBOX_TABLE[addr_b];
  end

endmodule

### hdl/aes_subbytes_shiftrows_row.sv
// aes subbytes and shiftrows on one row of the state
//
// usage:
//   an input row (row_index plus four column bytes) transfers on a rising
//   edge with start high and busy low. busy is never raised, so a row can
//   transfer on every cycle.
//   the row comes back on result, marked by done for exactly one cycle:
//   out_byte k is the substituted byte of column (row_index + k) mod 4.
//   the registered s-box rom read comes first, then the rotation into
//   the result register. throughput is one row a cycle, set by the two
//   dual-port s-box roms that look up all four bytes at once.
//   the receiver cannot hold a result off; each one is shown for one cycle.
//   synchronous reset clears the pipeline valid flags, so no done follows
//   a row that was in flight at reset. the roms need no clearing.
`include "assert_macros.svh"

module aes_subbytes_shiftrows_row (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  aes_ssr_pkg::row_in_t  item,
  output logic                  done,
  output aes_ssr_pkg::row_out_t result
);

  logic                   accept;
  logic                   s1_valid;
  aes_ssr_pkg::row_idx_t  s1_row;
  aes_ssr_pkg::byte_t     sub [4];
  aes_ssr_pkg::row_out_t  result_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  aes_ssr_sbox_rom u_rom_lo (
    .clk    (clk),
    .addr_a (item.in_byte0),
    .addr_b (item.in_byte1),
    .data_a (sub[0]),
    .data_b (sub[1])
  );

  aes_ssr_sbox_rom u_rom_hi (
    .clk    (clk),
    .addr_a (item.in_byte2),
    .addr_b (item.in_byte3),
    .data_a (sub[2]),
    .data_b (sub[3])
  );

  // row index travels alongside the rom read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_row <= item.row_index;
  end

  // left rotation by the row index, index arithmetic wraps mod 4
  always_comb begin
    result_next.out_byte0 = sub[s1_row];
    result_next.out_byte1 = sub[aes_ssr_pkg::row_idx_t'(s1_row + 2'd1)];
    result_next.out_byte2 = sub[aes_ssr_pkg::row_idx_t'(s1_row + 2'd2)];
    result_next.out_byte3 = sub[aes_ssr_pkg::row_idx_t'(s1_row + 2'd3)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    result <= result_next;
  end

  `ASSERT_NEXT(a_accept_to_s1, clk, rst, accept, s1_valid)
  `ASSERT_NEXT(a_s1_to_done, clk, rst, s1_valid, done)
  `ASSERT_IMPLIES(a_done_has_source, clk, rst, done, $past(accept, 2))
  `ASSERT_IMPLIES(a_never_busy, clk, rst, start, !busy)

endmodule

### dv/aes_ssr_row_checker.sv
// checker for the subbytes/shiftrows row block: predicts each row and compares the results
`timescale 1ns / 1ps

module aes_ssr_row_checker
  import aes_ssr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  row_in_t     item,
  input  logic        done,
  input  row_out_t    result,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned checked
);

  localparam byte_t AFFINE_ROWS [8] = '{
    8'd241, 8'd227, 8'd199, 8'd143, 8'd31, 8'd62, 8'd124, 8'd248
  };
  localparam byte_t REDUCE_POLY  = 8'h1b;
  localparam byte_t AFFINE_CONST = 8'h63;

  row_out_t    expected_rows [$];
  int unsigned fail_count = 0;
  int unsigned checked_count = 0;

  function automatic byte_t gf_mult(byte_t a, byte_t b);
    byte_t acc;
    byte_t x;
    byte_t y;
    acc = '0;
    x = a;
    y = b;
    for (int k = 0; k < 8; k++) begin
      if (y[0]) acc ^= x;
      y = y >> 1;
      x = x[7] ? byte_t'((x << 1) ^ REDUCE_POLY) : byte_t'(x << 1);
    end
    return acc;
  endfunction

  // inverse as a^254, which leaves zero at zero
  function automatic byte_t gf_inverse(byte_t a);
    byte_t acc;
    byte_t sq;
    byte_t e;
    acc = 8'h01;
    sq = a;
    e = 8'd254;
    while (e != 0) begin
      if (e[0]) acc = gf_mult(acc, sq);
      sq = gf_mult(sq, sq);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic byte_t sub_byte(byte_t a);
    byte_t inv;
    byte_t res;
    inv = gf_inverse(a);
    for (int i = 0; i < 8; i++) res[i] = ^(AFFINE_ROWS[i] & inv);
    return res ^ AFFINE_CONST;
  endfunction

  function automatic row_out_t subshift_row(row_in_t r);
    byte_t    sub [4];
    row_out_t o;
    int       rot;
    sub[0] = sub_byte(r.in_byte0);
    sub[1] = sub_byte(r.in_byte1);
    sub[2] = sub_byte(r.in_byte2);
    sub[3] = sub_byte(r.in_byte3);
    rot = r.row_index;
    o.out_byte0 = sub[rot];
    o.out_byte1 = sub[(rot + 1) % 4];
    o.out_byte2 = sub[(rot + 2) % 4];
    o.out_byte3 = sub[(rot + 3) % 4];
    return o;
  endfunction

  task automatic compare_byte(string field, byte_t exp_val, byte_t act_val);
    if (exp_val !== act_val) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    row_out_t exp_row;
    if (!rst) begin
      // push before pop so a zero-latency result would still find its row
      if (start && !busy) expected_rows.push_back(subshift_row(item));
      if (done) begin
        if (expected_rows.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, got %h", $time, result);
        end else begin
          exp_row = expected_rows.pop_front();
          checked_count++;
          compare_byte("out_byte0", exp_row.out_byte0, result.out_byte0);
          compare_byte("out_byte1", exp_row.out_byte1, result.out_byte1);
          compare_byte("out_byte2", exp_row.out_byte2, result.out_byte2);
          compare_byte("out_byte3", exp_row.out_byte3, result.out_byte3);
        end
      end
    end
    mismatches <= fail_count;
    pending    <= expected_rows.size();
    checked    <= checked_count;
  end

endmodule

### dv/aes_subbytes_shiftrows_row_tb.sv
// testbench top for the subbytes/shiftrows row block: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module aes_subbytes_shiftrows_row_tb;
  import aes_ssr_pkg::*;

  localparam int unsigned RANDOM_ROWS    = 1000;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  logic     done;
  row_in_t  item = '0;
  row_out_t result;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned stall_cycles = 0;
  int unsigned rows_sent = 0;
  int unsigned directed_rows = 0;
  bit          idling_on = 1'b1;

  aes_subbytes_shiftrows_row dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  aes_ssr_row_checker row_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  // no transfer in either direction for too long means the block has hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // weight towards zero, all-ones and single-bit bytes
  function automatic byte_t rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return byte_t'(1 << $urandom_range(7));
      default: return byte_t'($urandom);
    endcase
  endfunction

  function automatic row_in_t random_row();
    row_in_t r;
    r.row_index = row_idx_t'($urandom_range(3));
    r.in_byte0  = rand_byte();
    r.in_byte1  = rand_byte();
    r.in_byte2  = rand_byte();
    r.in_byte3  = rand_byte();
    return r;
  endfunction

  function automatic row_in_t make_row(row_idx_t idx, byte_t b0, byte_t b1, byte_t b2,
                                       byte_t b3);
    row_in_t r;
    r.row_index = idx;
    r.in_byte0  = b0;
    r.in_byte1  = b1;
    r.in_byte2  = b2;
    r.in_byte3  = b3;
    return r;
  endfunction

  task automatic send_row(row_in_t r);
    while (idling_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      item  <= random_row();
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= r;
    do @(posedge clk); while (busy);
    rows_sent++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // every rotation with zero, one, 0x7f and all-ones bytes
    for (int rr = 0; rr < 4; rr++)
      send_row(make_row(row_idx_t'(rr), 8'h00, 8'h01, 8'h7f, 8'hff));
    for (int rr = 0; rr < 4; rr++)
      send_row(make_row(row_idx_t'(rr), 8'h00, 8'h00, 8'h00, 8'h00));
    send_row(make_row(2'd3, 8'hff, 8'hff, 8'hff, 8'hff));
    for (int rr = 0; rr < 4; rr++)
      send_row(make_row(row_idx_t'(rr), 8'h11, 8'h22, 8'h33, 8'h44));
    send_row(make_row(2'd1, 8'h80, 8'h40, 8'h20, 8'h10));
    send_row(make_row(2'd2, 8'h08, 8'h04, 8'h02, 8'h01));
    directed_rows = rows_sent;

    for (int n = 0; n < RANDOM_ROWS; n++) begin
      // back-to-back transfers through the middle of the run
      idling_on = !(n >= 400 && n < 650);
      send_row(random_row());
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);

    $display("drove %0d rows (%0d directed) over all four rotations, checked %0d results",
             rows_sent, directed_rows, checked);
    $display("bytes biased to zero, all-ones and single bits; idle gaps plus a gap-free burst");
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/aes_ssr_pkg.sv
hdl/aes_ssr_sbox_rom.sv
hdl/aes_subbytes_shiftrows_row.sv
dv/aes_ssr_row_checker.sv
dv/aes_subbytes_shiftrows_row_tb.sv
